FILE: design/v3au_pkg.sv
// Shared widths, command codes, pipeline payload types and saturation helpers
// for the three-component vector unit. No dependencies.
`default_nettype none

package v3au_pkg;

    localparam int W          = 32;           // component width
    localparam int F          = 16;           // fraction bits
    localparam int PROD_W     = 2 * W;        // full product width
    localparam int SUM_W      = 2 * W + 2;    // sum of up to three products
    localparam int NUM_W      = W + F;        // divider numerator / quotient width
    localparam int RAD_W      = 2 * W;        // square root radicand width
    localparam int REM_W      = W + 1;        // square root remainder width
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQRT_STEPS = W;
    localparam int FRONT_STAGES = 5;

    localparam logic [SUM_W-1:0] RND_BIAS = SUM_W'((1 << F) - 1);

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_VDIV  = 4'd3,
        CMD_DOT   = 4'd4,
        CMD_CROSS = 4'd5,
        CMD_MAG   = 4'd6,
        CMD_NORM  = 4'd7,
        CMD_SDIV  = 4'd8
    } cmd_t;

    typedef logic signed [W-1:0] comp_t;

    typedef struct packed {
        logic  clip;
        comp_t val;
    } sat_t;

    // payload from the product front end through the square root
    typedef struct packed {
        cmd_t              cmd;
        comp_t [2:0]       a;
        comp_t             s;
        comp_t [2:0]       r;
        comp_t             sc;
        logic              clip;
        logic [RAD_W-1:0]  sq;
    } ctl_t;

    // payload carried alongside the divider lanes
    typedef struct packed {
        logic        use_q;
        logic        dz;
        logic [2:0]  neg;
        comp_t [2:0] r;
        comp_t       sc;
        logic        clip;
    } dctl_t;

    function automatic logic [W-1:0] abs_comp(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // clip a wide signed value to the component range
    function automatic sat_t sat_wide(input logic [SUM_W-1:0] v);
        sat_t res;
        logic [SUM_W-W:0] top;
        top = v[SUM_W-1:W-1];
        if (top == '0 || top == '1)
        begin
            res.clip = 1'b0;
            res.val  = v[W-1:0];
        end
        else
        begin
            res.clip = 1'b1;
            res.val  = v[SUM_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    // clip a sign and magnitude to the component range
    function automatic sat_t sat_mag(input logic neg, input logic [NUM_W-1:0] m);
        sat_t res;
        logic [NUM_W-W:0] hi;
        logic over;
        hi   = m[NUM_W-1:W-1];
        over = (hi != '0) && !(neg && hi == (NUM_W-W+1)'(1) && m[W-2:0] == '0);
        if (over)
        begin
            res.clip = 1'b1;
            res.val  = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            res.clip = 1'b0;
            res.val  = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/vec3_arith_unit_core.sv
// Three-component Q16.16 vector unit: top level with divide setup and output stage.
// Depends on v3au_pkg, v3au_front, v3au_sqrt, v3au_div.
// Pipeline order: front end, square root, divide setup, divide, output register.
// Throughput: one item per cycle; a result not taken at the output holds the whole pipe.
// Every item passes the 48-step divider and the 32-step square root.
// Reset clears the valid bits only; no other state.
`default_nettype none

module vec3_arith_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  cmd,
    input  wire logic signed [31:0] a_x,
    input  wire logic signed [31:0] a_y,
    input  wire logic signed [31:0] a_z,
    input  wire logic signed [31:0] b_x,
    input  wire logic signed [31:0] b_y,
    input  wire logic signed [31:0] b_z,
    input  wire logic signed [31:0] scalar_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] scalar_out,
    output logic             div_zero,
    output logic             saturated
);

    localparam int W     = v3au_pkg::W;
    localparam int F     = v3au_pkg::F;
    localparam int NUM_W = v3au_pkg::NUM_W;

    logic en;

    v3au_pkg::comp_t a_arr [3];
    v3au_pkg::comp_t b_arr [3];

    logic           fr_valid;
    v3au_pkg::ctl_t fr_ctl;
    logic           sq_valid;
    v3au_pkg::ctl_t sq_ctl;
    logic [W-1:0]   root;

    logic [NUM_W-1:0] num_next [3];
    logic [NUM_W-1:0] num_reg  [3];
    logic [W-1:0]     den_next [3];
    logic [W-1:0]     den_reg  [3];
    v3au_pkg::dctl_t  dctl_next;
    v3au_pkg::dctl_t  dctl_reg;
    logic             sv_reg;

    logic             dv_valid;
    logic [NUM_W-1:0] quo [3];
    v3au_pkg::dctl_t  dv_ctl;

    logic [W-1:0]   abs_a [3];
    logic [W-1:0]   abs_s;
    v3au_pkg::sat_t mag_sat;
    v3au_pkg::sat_t q_sat [3];

    v3au_pkg::comp_t r_next [3];
    v3au_pkg::comp_t r_reg  [3];
    v3au_pkg::comp_t sc_reg;
    logic            dz_reg;
    logic            clip_next;
    logic            clip_reg;
    logic            ov_reg;

    assign en       = out_ready || !ov_reg;
    assign in_ready = en;

    assign a_arr[0] = a_x;
    assign a_arr[1] = a_y;
    assign a_arr[2] = a_z;
    assign b_arr[0] = b_x;
    assign b_arr[1] = b_y;
    assign b_arr[2] = b_z;

    v3au_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .a_in      (a_arr),
        .b_in      (b_arr),
        .s_in      (scalar_in),
        .out_valid (fr_valid),
        .out_ctl   (fr_ctl)
    );

    v3au_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_ctl    (fr_ctl),
        .out_valid (sq_valid),
        .out_ctl   (sq_ctl),
        .root      (root)
    );

    // divide setup: pick numerators, divisors and quotient signs
    always_comb
    begin
        abs_s   = v3au_pkg::abs_comp(sq_ctl.s);
        mag_sat = v3au_pkg::sat_mag(1'b0, NUM_W'(root));
        dctl_next.use_q = 1'b0;
        dctl_next.dz    = 1'b0;
        dctl_next.neg   = '0;
        dctl_next.r     = sq_ctl.r;
        dctl_next.sc    = sq_ctl.sc;
        dctl_next.clip  = sq_ctl.clip;
        for (int k = 0; k < 3; k++)
        begin
            abs_a[k]    = v3au_pkg::abs_comp(sq_ctl.a[k]);
            num_next[k] = {abs_a[k], {F{1'b0}}};
            den_next[k] = abs_s;
        end
        case (sq_ctl.cmd)
            v3au_pkg::CMD_VDIV:
            begin
                for (int k = 0; k < 3; k++)
                    dctl_next.neg[k] = sq_ctl.a[k][W-1] ^ sq_ctl.s[W-1];
                dctl_next.dz    = (sq_ctl.s == '0);
                dctl_next.use_q = (sq_ctl.s != '0);
            end
            v3au_pkg::CMD_NORM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dctl_next.neg[k] = sq_ctl.a[k][W-1];
                    den_next[k]      = root;
                end
                dctl_next.use_q = (root != '0);
            end
            v3au_pkg::CMD_SDIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    num_next[k]      = {abs_s, {F{1'b0}}};
                    den_next[k]      = abs_a[k];
                    dctl_next.neg[k] = sq_ctl.a[k][W-1] ^ sq_ctl.s[W-1];
                end
                dctl_next.dz    = (sq_ctl.a[0] == '0) || (sq_ctl.a[1] == '0)
                                  || (sq_ctl.a[2] == '0);
                dctl_next.use_q = !dctl_next.dz;
            end
            v3au_pkg::CMD_MAG:
            begin
                dctl_next.sc   = mag_sat.val;
                dctl_next.clip = mag_sat.clip;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else if (en)
            sv_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= num_next[k];
                den_reg[k] <= den_next[k];
            end
            dctl_reg <= dctl_next;
        end
    end

    v3au_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_ctl    (dctl_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_ctl   (dv_ctl)
    );

    // output stage: take quotients where a divide ran, else the earlier results
    always_comb
    begin
        clip_next = dv_ctl.clip;
        for (int k = 0; k < 3; k++)
        begin
            q_sat[k]  = v3au_pkg::sat_mag(dv_ctl.neg[k], quo[k]);
            r_next[k] = dv_ctl.r[k];
        end
        if (dv_ctl.use_q)
        begin
            for (int k = 0; k < 3; k++)
                r_next[k] = q_sat[k].val;
            clip_next = q_sat[0].clip | q_sat[1].clip | q_sat[2].clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                r_reg[k] <= r_next[k];
            sc_reg   <= dv_ctl.sc;
            dz_reg   <= dv_ctl.dz;
            clip_reg <= clip_next;
        end
    end

    assign out_valid  = ov_reg;
    assign r_x        = r_reg[0];
    assign r_y        = r_reg[1];
    assign r_z        = r_reg[2];
    assign scalar_out = sc_reg;
    assign div_zero   = dz_reg;
    assign saturated  = clip_reg;

endmodule

`default_nettype wire

FILE: design/v3au_front.sv
// Front end: operand select, products, sums, toward-zero shift and saturation.
// Five register stages. Depends on v3au_pkg.
`default_nettype none

module v3au_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [3:0]       in_cmd,
    input  wire v3au_pkg::comp_t  a_in [3],
    input  wire v3au_pkg::comp_t  b_in [3],
    input  wire v3au_pkg::comp_t  s_in,
    output logic                  out_valid,
    output v3au_pkg::ctl_t        out_ctl
);

    localparam int W     = v3au_pkg::W;
    localparam int SUM_W = v3au_pkg::SUM_W;

    // stage 1: operands
    v3au_pkg::comp_t ma_next [6];
    v3au_pkg::comp_t mb_next [6];
    v3au_pkg::comp_t ma_reg [6];
    v3au_pkg::comp_t mb_reg [6];
    v3au_pkg::comp_t a1_reg [3];
    v3au_pkg::comp_t b1_reg [3];
    v3au_pkg::comp_t s1_reg;
    v3au_pkg::cmd_t  cmd1_reg;
    logic            v1_reg;

    // stage 2: products
    logic signed [v3au_pkg::PROD_W-1:0] p_reg [6];
    v3au_pkg::comp_t a2_reg [3];
    v3au_pkg::comp_t b2_reg [3];
    v3au_pkg::comp_t s2_reg;
    v3au_pkg::cmd_t  cmd2_reg;
    logic            v2_reg;

    // stage 3: combined wide values
    logic signed [SUM_W-1:0] w_next [4];
    logic signed [SUM_W-1:0] w_reg [4];
    logic [v3au_pkg::RAD_W-1:0] sq_next;
    logic [v3au_pkg::RAD_W-1:0] sq3_reg;
    logic                       shift_next;
    logic                       shift_reg;
    v3au_pkg::comp_t a3_reg [3];
    v3au_pkg::comp_t s3_reg;
    v3au_pkg::cmd_t  cmd3_reg;
    logic            v3_reg;

    // stage 4: shifted values
    logic signed [SUM_W-1:0] h_next [4];
    logic signed [SUM_W-1:0] h_reg [4];
    logic [v3au_pkg::RAD_W-1:0] sq4_reg;
    v3au_pkg::comp_t a4_reg [3];
    v3au_pkg::comp_t s4_reg;
    v3au_pkg::cmd_t  cmd4_reg;
    logic            v4_reg;

    // stage 5: saturated results
    v3au_pkg::ctl_t ctl_next;
    v3au_pkg::ctl_t ctl_reg;
    logic           v5_reg;

    logic signed [SUM_W-1:0] ext_p [6];
    logic signed [SUM_W-1:0] tmp [4];
    v3au_pkg::sat_t          st [4];
    v3au_pkg::cmd_t          cmd_in;

    assign cmd_in = v3au_pkg::cmd_t'(in_cmd);

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            ma_next[k] = '0;
            mb_next[k] = '0;
        end
        case (cmd_in) inside
            v3au_pkg::CMD_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma_next[k] = a_in[k];
                    mb_next[k] = s_in;
                end
            end
            v3au_pkg::CMD_DOT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma_next[k] = a_in[k];
                    mb_next[k] = b_in[k];
                end
            end
            v3au_pkg::CMD_MAG, v3au_pkg::CMD_NORM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ma_next[k] = a_in[k];
                    mb_next[k] = a_in[k];
                end
            end
            v3au_pkg::CMD_CROSS:
            begin
                ma_next[0] = a_in[1]; mb_next[0] = b_in[2];
                ma_next[3] = a_in[2]; mb_next[3] = b_in[1];
                ma_next[1] = a_in[2]; mb_next[1] = b_in[0];
                ma_next[4] = a_in[0]; mb_next[4] = b_in[2];
                ma_next[2] = a_in[0]; mb_next[2] = b_in[1];
                ma_next[5] = a_in[1]; mb_next[5] = b_in[0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            ext_p[k] = SUM_W'(p_reg[k]);
        for (int k = 0; k < 4; k++)
            w_next[k] = '0;
        sq_next    = '0;
        shift_next = 1'b0;
        case (cmd2_reg) inside
            v3au_pkg::CMD_ADD:
                for (int k = 0; k < 3; k++)
                    w_next[k] = SUM_W'(a2_reg[k]) + SUM_W'(b2_reg[k]);
            v3au_pkg::CMD_SUB:
                for (int k = 0; k < 3; k++)
                    w_next[k] = SUM_W'(a2_reg[k]) - SUM_W'(b2_reg[k]);
            v3au_pkg::CMD_SCALE:
            begin
                shift_next = 1'b1;
                for (int k = 0; k < 3; k++)
                    w_next[k] = ext_p[k];
            end
            v3au_pkg::CMD_CROSS:
            begin
                shift_next = 1'b1;
                for (int k = 0; k < 3; k++)
                    w_next[k] = ext_p[k] - ext_p[k+3];
            end
            v3au_pkg::CMD_DOT:
            begin
                shift_next = 1'b1;
                w_next[3]  = ext_p[0] + ext_p[1] + ext_p[2];
            end
            v3au_pkg::CMD_MAG, v3au_pkg::CMD_NORM:
                sq_next = p_reg[0] + p_reg[1] + p_reg[2];
            default: ;
        endcase
    end

    // truncate toward zero: bias negative values before the arithmetic shift
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            tmp[k] = w_reg[k] + (w_reg[k][SUM_W-1] ? $signed(v3au_pkg::RND_BIAS)
                                                    : $signed({SUM_W{1'b0}}));
            h_next[k] = shift_reg ? (tmp[k] >>> v3au_pkg::F) : w_reg[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            st[k] = v3au_pkg::sat_wide(h_reg[k]);
        ctl_next.cmd  = cmd4_reg;
        for (int k = 0; k < 3; k++)
        begin
            ctl_next.a[k] = a4_reg[k];
            ctl_next.r[k] = st[k].val;
        end
        ctl_next.s    = s4_reg;
        ctl_next.sc   = st[3].val;
        ctl_next.clip = st[0].clip | st[1].clip | st[2].clip | st[3].clip;
        ctl_next.sq   = sq4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                ma_reg[k] <= ma_next[k];
                mb_reg[k] <= mb_next[k];
                p_reg[k]  <= ma_reg[k] * mb_reg[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                a1_reg[k] <= a_in[k];
                b1_reg[k] <= b_in[k];
                a2_reg[k] <= a1_reg[k];
                b2_reg[k] <= b1_reg[k];
                a3_reg[k] <= a2_reg[k];
                a4_reg[k] <= a3_reg[k];
            end
            for (int k = 0; k < 4; k++)
            begin
                w_reg[k] <= w_next[k];
                h_reg[k] <= h_next[k];
            end
            s1_reg    <= s_in;
            s2_reg    <= s1_reg;
            s3_reg    <= s2_reg;
            s4_reg    <= s3_reg;
            cmd1_reg  <= cmd_in;
            cmd2_reg  <= cmd1_reg;
            cmd3_reg  <= cmd2_reg;
            cmd4_reg  <= cmd3_reg;
            sq3_reg   <= sq_next;
            sq4_reg   <= sq3_reg;
            shift_reg <= shift_next;
            ctl_reg   <= ctl_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

FILE: design/v3au_sqrt.sv
// Pipelined floor square root, one result bit per stage, payload carried along.
// Depends on v3au_pkg.
`default_nettype none

module v3au_sqrt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire v3au_pkg::ctl_t  in_ctl,
    output logic                 out_valid,
    output v3au_pkg::ctl_t       out_ctl,
    output logic [v3au_pkg::W-1:0] root
);

    localparam int N     = v3au_pkg::SQRT_STEPS;
    localparam int W     = v3au_pkg::W;
    localparam int REM_W = v3au_pkg::REM_W;
    localparam int RAD_W = v3au_pkg::RAD_W;

    logic [REM_W-1:0] rem_reg  [N];
    logic [W-1:0]     root_reg [N];
    logic [RAD_W-1:0] rad_reg  [N];
    v3au_pkg::ctl_t   ctl_reg  [N];
    logic             v_reg    [N];

    for (genvar j = 0; j < N; j++)
    begin : g_step
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] rem_next;
        logic [W-1:0]     root_in;
        logic [W-1:0]     root_next;
        logic [RAD_W-1:0] rad_in;
        logic [RAD_W-1:0] rad_next;
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        v3au_pkg::ctl_t   ctl_in;
        logic             v_in;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_ctl.sq;
            assign ctl_in  = in_ctl;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign ctl_in  = ctl_reg[j-1];
            assign v_in    = v_reg[j-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            t        = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial    = {1'b0, root_in, 2'b01};
            rad_next = {rad_in[RAD_W-3:0], 2'b00};
            if (t >= trial)
            begin
                rem_next  = REM_W'(t - trial);
                root_next = {root_in[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = t[REM_W-1:0];
                root_next = {root_in[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= rad_next;
                ctl_reg[j]  <= ctl_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    assign root      = root_reg[N-1];

endmodule

`default_nettype wire

FILE: design/v3au_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage,
// payload carried along. Depends on v3au_pkg.
`default_nettype none

module v3au_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [v3au_pkg::NUM_W-1:0] num [3],
    input  wire logic [v3au_pkg::W-1:0]     den [3],
    input  wire v3au_pkg::dctl_t            in_ctl,
    output logic                           out_valid,
    output logic [v3au_pkg::NUM_W-1:0]     quo [3],
    output v3au_pkg::dctl_t                out_ctl
);

    localparam int N     = v3au_pkg::DIV_STEPS;
    localparam int W     = v3au_pkg::W;
    localparam int NUM_W = v3au_pkg::NUM_W;

    logic [W-1:0]     rem_reg [3][N];
    logic [NUM_W-1:0] nq_reg  [3][N];
    logic [W-1:0]     den_reg [3][N];
    v3au_pkg::dctl_t  ctl_reg [N];
    logic             v_reg   [N];

    for (genvar j = 0; j < N; j++)
    begin : g_step
        v3au_pkg::dctl_t ctl_in;
        logic            v_in;

        if (j == 0)
        begin : g_first
            assign ctl_in = in_ctl;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign ctl_in = ctl_reg[j-1];
            assign v_in   = v_reg[j-1];
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [W-1:0]     rem_in;
            logic [W-1:0]     rem_next;
            logic [NUM_W-1:0] nq_in;
            logic [NUM_W-1:0] nq_next;
            logic [W-1:0]     den_in;
            logic [W:0]       t;
            logic             ge;

            if (j == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = num[l];
                assign den_in = den[l];
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[l][j-1];
                assign nq_in  = nq_reg[l][j-1];
                assign den_in = den_reg[l][j-1];
            end

            // shift the next numerator bit into the remainder, quotient bit in below
            always_comb
            begin
                t        = {rem_in, nq_in[NUM_W-1]};
                ge       = (t >= {1'b0, den_in});
                rem_next = ge ? W'(t - {1'b0, den_in}) : t[W-1:0];
                nq_next  = {nq_in[NUM_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][j] <= rem_next;
                    nq_reg[l][j]  <= nq_next;
                    den_reg[l][j] <= den_in;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ctl_reg[j] <= ctl_in;
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_ctl   = ctl_reg[N-1];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign quo[l] = nq_reg[l][N-1];
    end

endmodule

`default_nettype wire
